// ===== sv/rpfw_pkg.sv =====
// Package for the rectangle patch frame writer: word types, codes,
// controller states and the command/status structs between ctrl and datapath.
// No dependencies.
`default_nettype none

package rpfw_pkg;

   // Field widths fixed by the interface
   localparam int ADDR_W  = 22;
   localparam int COORD_W = 10;
   localparam int SIZE_W  = 11;
   localparam int PITCH_W = 13;
   localparam int BPP_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // Largest bytes per pixel; larger register values clamp to it
   localparam logic [BPP_W-1:0] MAX_BPP = 3'd4;

   // One past the highest frame byte address
   localparam logic [ADDR_W:0] ADDR_SPAN = 23'h400000;

   // Register reset values
   localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
   localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 11'd1024;
   localparam logic [BPP_W-1:0]  BPP_RST          = 3'd4;

   // Cycles the derived frame values need after a register write
   localparam logic [1:0] SETTLE_CYCLES = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_PIXEL = 2'd2;

   // Input word kinds
   localparam logic CMD_HEADER = 1'b0;
   localparam logic CMD_DATA   = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_WRITTEN = 2'd0;
   localparam logic [1:0] STATUS_PADDING = 2'd1;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd2;
   localparam logic [1:0] STATUS_NO_RECT = 2'd3;

   typedef struct packed {
      logic               cmd;
      logic [COORD_W-1:0] rect_x;
      logic [COORD_W-1:0] rect_y;
      logic [SIZE_W-1:0]  rect_width;
      logic [SIZE_W-1:0]  rect_height;
      logic [PITCH_W-1:0] line_pitch;
      logic [7:0]         data_byte;
      logic               final_byte;
   } req_word_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [7:0]        byte_value;
      logic [1:0]        status;
      logic              rect_done;
      logic              list_done;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ST_SETTLE,
      ST_READY,
      ST_HDR_MUL,
      ST_HDR_ADD
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic cfg_we;
      logic load_hdr;
      logic hdr_mul;
      logic hdr_add;
      logic load_data;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_header;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== sv/rect_patch_frame_writer.sv =====
// Top level of the rectangle patch frame writer: controller plus datapath.
// Depends on rpfw_pkg, rpfw_ctrl and rpfw_datapath.
`default_nettype none

// A header word loads one changed rectangle; each following data word is one
// source byte and yields one result word in the next cycle, registered
// on rsp_. Data words are taken one per cycle while the result register
// drains. A header word is handled in steps: accept, a multiply step (row
// times stride, column times bytes per pixel) and the row start add. After
// reset and after every register write the frame stride and byte limit are
// recomputed by a two-stage multiplier pipeline, and req_ready stays low
// during the settle wait. Register writes are taken at any time (csr_ready
// is tied high) and must only be issued while the block is idle.
module rect_patch_frame_writer
   import rpfw_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_word_type          req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_word_type               rsp_word,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   ctrl_cmd_type  dp_cmd;
   dp_status_type dp_status;

   assign csr_ready = 1'b1;

   rpfw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   rpfw_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .dp_cmd    (dp_cmd),
      .req_word  (req_word),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .dp_status (dp_status),
      .rsp_word  (rsp_word)
   );

`ifndef SYNTHESIS
   // Header sequencing blocks the input for the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_word.cmd == CMD_HEADER) |=> !req_ready)
      else $error("input taken during header sequencing");

   // Every data word yields a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_word.cmd == CMD_DATA) |=> rsp_valid)
      else $error("data word produced no result");

   // Address and byte are zero unless the byte is written
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status != STATUS_WRITTEN) |->
      (rsp_word.address == '0 && rsp_word.byte_value == '0))
      else $error("nonzero address on a non-write result");

   // A rectangle can only end while one is active
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.rect_done) |-> (rsp_word.status != STATUS_NO_RECT))
      else $error("rectangle end without active rectangle");
`endif

endmodule

`default_nettype wire

// ===== sv/rpfw_ctrl.sv =====
// Controller for the rectangle patch frame writer: handshakes, header
// sequencing and settle wait after register writes. Depends on rpfw_pkg.
`default_nettype none

module rpfw_ctrl
   import rpfw_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire logic          csr_valid,
   input  wire dp_status_type dp_status,
   output ctrl_cmd_type       dp_cmd
);

   ctrl_state_type state_ff, state_in;
   logic [1:0]     settle_ff, settle_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           req_acc;

   // State, settle counter and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SETTLE;
         settle_ff    <= SETTLE_CYCLES;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         settle_ff    <= settle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      settle_in = settle_ff;
      req_ready = 1'b0;
      dp_cmd    = '0;

      dp_cmd.cfg_we = csr_valid;

      unique case (state_ff)
         ST_SETTLE: begin
            if (settle_ff == 2'd0) begin
               state_in = ST_READY;
            end else begin
               settle_in = settle_ff - 2'd1;
            end
         end
         ST_READY: begin
            req_ready = !rsp_valid_ff || rsp_ready;
         end
         ST_HDR_MUL: begin
            dp_cmd.hdr_mul = 1'b1;
            state_in       = ST_HDR_ADD;
         end
         ST_HDR_ADD: begin
            dp_cmd.hdr_add = 1'b1;
            state_in       = ST_READY;
         end
         default: begin
            state_in = ST_SETTLE;
         end
      endcase

      req_acc          = req_valid && req_ready;
      dp_cmd.load_hdr  = req_acc && dp_status.is_header;
      dp_cmd.load_data = req_acc && !dp_status.is_header;
      if (dp_cmd.load_hdr) begin
         state_in = ST_HDR_MUL;
      end

      // A register write restarts the settle wait
      if (csr_valid) begin
         state_in  = ST_SETTLE;
         settle_in = SETTLE_CYCLES;
      end
   end

   // Output word register: one result per data word
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (dp_cmd.load_data) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== sv/rpfw_datapath.sv =====
// Datapath for the rectangle patch frame writer: registers, frame geometry,
// rectangle walk and result word. Depends on rpfw_pkg.
`default_nettype none

module rpfw_datapath
   import rpfw_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctrl_cmd_type          dp_cmd,
   input  wire req_word_type          req_word,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output dp_status_type              dp_status,
   output rsp_word_type               rsp_word
);

   // Configuration registers
   logic [SIZE_W-1:0] frame_width_ff, frame_height_ff;
   logic [BPP_W-1:0]  bpp_ff;

   // Derived frame geometry
   logic [BPP_W-1:0]   eff_bpp;
   logic [13:0]        stride_prod;
   logic [PITCH_W-1:0] stride_ff;
   logic [ADDR_W-1:0]  area_prod, area_ff;
   logic [BPP_W-1:0]   bppd_ff;
   logic [24:0]        limit_prod;
   logic [ADDR_W:0]    limit_in, limit_ff;

   // Header staging
   logic [COORD_W-1:0] hx_ff, hy_ff;
   logic [SIZE_W-1:0]  hw_ff;
   logic [ADDR_W:0]    yprod_in, yprod_ff;
   logic [PITCH_W-1:0] xoff_in, xoff_ff;
   logic [13:0]        rcopy_prod;
   logic [ADDR_W+1:0]  hdr_sum;

   // Rectangle walk state
   logic               active_ff, active_in;
   logic [SIZE_W-1:0]  row_count_ff, row_count_in;
   logic [PITCH_W-1:0] column_ff, column_in;
   logic [ADDR_W-1:0]  row_start_ff, row_start_in;
   logic               beyond_ff, beyond_in;
   logic [PITCH_W-1:0] row_copy_ff, row_copy_in;
   logic [PITCH_W-1:0] pitch_ff, pitch_in;
   logic [SIZE_W-1:0]  rows_total_ff, rows_total_in;

   // Data step
   logic [ADDR_W:0]    byte_addr;
   logic [PITCH_W-1:0] column_next;
   logic [SIZE_W-1:0]  row_next;
   logic [ADDR_W:0]    row_adv;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   assign dp_status.is_header = (req_word.cmd == CMD_HEADER);

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         bpp_ff          <= BPP_RST;
      end else if (dp_cmd.cfg_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:     frame_width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT:    frame_height_ff <= csr_wdata;
            CSR_BYTES_PER_PIXEL: bpp_ff          <= csr_wdata[BPP_W-1:0];
            default: ;
         endcase
      end
   end

   // Geometry pipeline: row stride and frame byte limit
   assign eff_bpp     = (bpp_ff > MAX_BPP) ? MAX_BPP : bpp_ff;
   assign stride_prod = {3'b0, frame_width_ff} * {11'b0, eff_bpp};
   assign area_prod   = {11'b0, frame_width_ff} * {11'b0, frame_height_ff};
   assign limit_prod  = {3'b0, area_ff} * {22'b0, bppd_ff};
   assign limit_in    = (limit_prod > {2'b0, ADDR_SPAN}) ? ADDR_SPAN : limit_prod[ADDR_W:0];

   always_ff @(posedge clock) begin
      stride_ff <= stride_prod[PITCH_W-1:0];
      area_ff   <= area_prod;
      bppd_ff   <= eff_bpp;
      limit_ff  <= limit_in;
   end

   // Header: capture, multiply, then add
   assign yprod_in   = {13'b0, hy_ff} * {10'b0, stride_ff};
   assign xoff_in    = {3'b0, hx_ff} * {10'b0, eff_bpp};
   assign rcopy_prod = {3'b0, hw_ff} * {11'b0, eff_bpp};
   assign hdr_sum    = {1'b0, yprod_ff} + {11'b0, xoff_ff};

   always_ff @(posedge clock) begin
      if (dp_cmd.load_hdr) begin
         hx_ff <= req_word.rect_x;
         hy_ff <= req_word.rect_y;
         hw_ff <= req_word.rect_width;
      end
      if (dp_cmd.hdr_mul) begin
         yprod_ff <= yprod_in;
         xoff_ff  <= xoff_in;
      end
   end

   // Data step: address, status and walk update
   assign byte_addr   = {1'b0, row_start_ff} + {10'b0, column_ff};
   assign column_next = column_ff + 13'd1;
   assign row_next    = row_count_ff + 11'd1;
   assign row_adv     = {1'b0, row_start_ff} + {10'b0, stride_ff};

   always_comb begin
      active_in     = active_ff;
      row_count_in  = row_count_ff;
      column_in     = column_ff;
      row_start_in  = row_start_ff;
      beyond_in     = beyond_ff;
      row_copy_in   = row_copy_ff;
      pitch_in      = pitch_ff;
      rows_total_in = rows_total_ff;
      rsp_word_in   = rsp_word_ff;

      priority if (dp_cmd.load_hdr) begin
         rows_total_in = req_word.rect_height;
         pitch_in      = req_word.line_pitch;
         row_count_in  = '0;
         column_in     = '0;
         beyond_in     = 1'b0;
         active_in     = (req_word.rect_height != '0) && (req_word.line_pitch != '0);
      end else if (dp_cmd.hdr_mul) begin
         row_copy_in = rcopy_prod[PITCH_W-1:0];
      end else if (dp_cmd.hdr_add) begin
         row_start_in = hdr_sum[ADDR_W-1:0];
         beyond_in    = |hdr_sum[ADDR_W+1:ADDR_W];
      end else if (dp_cmd.load_data) begin
         rsp_word_in            = '0;
         rsp_word_in.list_done  = req_word.final_byte;
         if (!active_ff) begin
            rsp_word_in.status = STATUS_NO_RECT;
         end else begin
            priority if (column_ff >= row_copy_ff) begin
               rsp_word_in.status = STATUS_PADDING;
            end else if (beyond_ff || (byte_addr >= limit_ff)) begin
               rsp_word_in.status = STATUS_OUTSIDE;
            end else begin
               rsp_word_in.status     = STATUS_WRITTEN;
               rsp_word_in.address    = byte_addr[ADDR_W-1:0];
               rsp_word_in.byte_value = req_word.data_byte;
            end
            column_in = column_next;
            // End of a source row
            if (column_next >= pitch_ff) begin
               column_in    = '0;
               row_count_in = row_next;
               row_start_in = row_adv[ADDR_W-1:0];
               if (row_adv[ADDR_W]) begin
                  beyond_in = 1'b1;
               end
               if (row_next >= rows_total_ff) begin
                  rsp_word_in.rect_done = 1'b1;
                  active_in             = 1'b0;
               end
            end
         end
      end else begin
      end
   end

   // Walk control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         row_count_ff  <= '0;
         column_ff     <= '0;
         row_start_ff  <= '0;
         beyond_ff     <= 1'b0;
         row_copy_ff   <= '0;
         pitch_ff      <= '0;
         rows_total_ff <= '0;
      end else begin
         active_ff     <= active_in;
         row_count_ff  <= row_count_in;
         column_ff     <= column_in;
         row_start_ff  <= row_start_in;
         beyond_ff     <= beyond_in;
         row_copy_ff   <= row_copy_in;
         pitch_ff      <= pitch_in;
         rows_total_ff <= rows_total_in;
      end
   end

   // Result word register
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_word = rsp_word_ff;

endmodule

`default_nettype wire

// ===== bench/rect_patch_frame_writer_tb.sv =====
// Self-checking bench for rect_patch_frame_writer: directed rectangles, then
// random rectangle lists across several frame setups, checked by a predictor.
// Depends on rpfw_pkg and rect_patch_frame_writer.
`timescale 1ns / 100ps

module rect_patch_frame_writer_tb;
   import rpfw_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_QUOTA    = 34;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      req_word_type word;
      bit           typed;
      rsp_word_type known;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor copy of the registers and the rectangle walker
   logic [SIZE_W-1:0]  sh_width  = FRAME_WIDTH_RST;
   logic [SIZE_W-1:0]  sh_height = FRAME_HEIGHT_RST;
   logic [BPP_W-1:0]   sh_bpp    = BPP_RST;
   logic               pr_active = 1'b0;
   logic [SIZE_W-1:0]  pr_row = '0;
   logic [PITCH_W-1:0] pr_col = '0;
   logic [ADDR_W-1:0]  pr_row_base = '0;
   logic [PITCH_W-1:0] pr_row_bytes = '0;
   logic [PITCH_W-1:0] pr_pitch = '0;
   logic [SIZE_W-1:0]  pr_rows = '0;
   logic               pr_past_end = 1'b0;

   rsp_word_type write_results_due[$];
   directed_row_type plan[$];
   int  fail_count = 0;
   int  words_in = 0;
   int  results_seen = 0;
   int  status_seen[4] = '{0, 0, 0, 0};
   int  rects_closed = 0;
   int  quiet = 0;
   bit  steady = 1'b0;

   rect_patch_frame_writer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic logic [BPP_W-1:0] bpp_used();
      return (sh_bpp > MAX_BPP) ? MAX_BPP : sh_bpp;
   endfunction

   // Row starts at or past the address span mark the rest of the rectangle
   function automatic void place_row(input longint a);
      if (a >= longint'(ADDR_SPAN)) pr_past_end = 1'b1;
      pr_row_base = ADDR_W'(a);
   endfunction

   // Advance the rectangle walker by one accepted word
   task automatic advance_writer(input req_word_type w, output bit produced,
                                 output rsp_word_type r);
      longint eff, lim, a;
      eff = longint'(bpp_used());
      lim = longint'(sh_width) * longint'(sh_height) * eff;
      if (lim > longint'(ADDR_SPAN)) lim = longint'(ADDR_SPAN);
      r = '0;
      produced = (w.cmd == CMD_DATA);
      if (w.cmd == CMD_HEADER) begin
         pr_rows = w.rect_height;
         pr_pitch = w.line_pitch;
         pr_row_bytes = PITCH_W'(longint'(w.rect_width) * eff);
         pr_row = '0;
         pr_col = '0;
         pr_past_end = 1'b0;
         place_row(longint'(w.rect_y) * longint'(sh_width) * eff +
                   longint'(w.rect_x) * eff);
         pr_active = (w.rect_height != 0) && (w.line_pitch != 0);
      end else begin
         r.list_done = w.final_byte;
         if (!pr_active) begin
            r.status = STATUS_NO_RECT;
         end else begin
            a = longint'(pr_row_base) + longint'(pr_col);
            if (pr_col >= pr_row_bytes) begin
               r.status = STATUS_PADDING;
            end else if (pr_past_end || a >= lim) begin
               r.status = STATUS_OUTSIDE;
            end else begin
               r.status = STATUS_WRITTEN;
               r.address = ADDR_W'(a);
               r.byte_value = w.data_byte;
            end
            // step through the source row; wrap to the next frame row
            pr_col = PITCH_W'(pr_col + 1'b1);
            if (pr_col >= pr_pitch) begin
               pr_col = '0;
               pr_row = SIZE_W'(pr_row + 1'b1);
               place_row(longint'(pr_row_base) + longint'(sh_width) * eff);
               if (pr_row >= pr_rows) begin
                  r.rect_done = 1'b1;
                  pr_active = 1'b0;
               end
            end
         end
      end
   endtask

   function automatic req_word_type hdr(input int x, input int y, input int w,
                                        input int h, input int p);
      req_word_type r;
      r = '0;
      r.cmd = CMD_HEADER;
      r.rect_x = COORD_W'(x);
      r.rect_y = COORD_W'(y);
      r.rect_width = SIZE_W'(w);
      r.rect_height = SIZE_W'(h);
      r.line_pitch = PITCH_W'(p);
      return r;
   endfunction

   function automatic req_word_type dat(input int b, input bit fin);
      req_word_type r;
      r = '0;
      r.cmd = CMD_DATA;
      r.data_byte = 8'(b);
      r.final_byte = fin;
      return r;
   endfunction

   function automatic rsp_word_type res(input int addr, input int val,
                                        input logic [1:0] st, input bit rd,
                                        input bit ld);
      rsp_word_type r;
      r.address = ADDR_W'(addr);
      r.byte_value = 8'(val);
      r.status = st;
      r.rect_done = rd;
      r.list_done = ld;
      return r;
   endfunction

   // Present one word after a random gap and book its result on acceptance.
   // Called at a rising edge; returns at the edge that accepted the word.
   task automatic offer_word(input req_word_type w, input bit typed,
                             input rsp_word_type known);
      int gap;
      bit produced;
      rsp_word_type r;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      advance_writer(w, produced, r);
      if (produced) write_results_due.push_back(typed ? known : r);
      words_in++;
   endtask

   // Write all registers, the unused index included; called at a rising edge
   task automatic program_frame(input logic [CSR_DATA_W-1:0] width,
                                input logic [CSR_DATA_W-1:0] height,
                                input logic [CSR_DATA_W-1:0] bpp);
      logic [CSR_IDX_W-1:0]  idx[4];
      logic [CSR_DATA_W-1:0] val[4];
      idx = '{CSR_FRAME_WIDTH, CSR_FRAME_HEIGHT, CSR_BYTES_PER_PIXEL, CSR_UNUSED};
      val = '{width, height, bpp, CSR_DATA_W'($urandom)};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         do @(posedge clock); while (!csr_ready);
         case (idx[i])
            CSR_FRAME_WIDTH:     sh_width = val[i];
            CSR_FRAME_HEIGHT:    sh_height = val[i];
            CSR_BYTES_PER_PIXEL: sh_bpp = val[i][BPP_W-1:0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // Random rectangle lists: mostly complete rectangles with random bytes,
   // some abandoned early, some oversized or empty, some stray data words
   task automatic run_phase(input int quota);
      int taken, n, eff, row_bytes, xcap, ycap, roll;
      req_word_type w;
      logic [95:0] noise;
      taken = 0;
      while (taken < quota) begin
         noise = {$urandom, $urandom, $urandom};
         w = noise[$bits(req_word_type)-1:0];
         w.cmd = CMD_HEADER;
         eff = int'(bpp_used());
         xcap = (sh_width == 0 || sh_width > 1024) ? 1024 : int'(sh_width);
         ycap = (sh_height == 0 || sh_height > 1024) ? 1024 : int'(sh_height);
         roll = $urandom_range(0, 99);
         if (roll < 15) begin
            // full-range header fields; only a few bytes before moving on
            n = $urandom_range(0, 6);
         end else begin
            if (roll < 85) begin
               w.rect_x = COORD_W'($urandom_range(0, xcap - 1));
               w.rect_y = COORD_W'($urandom_range(0, ycap - 1));
            end
            w.rect_width = SIZE_W'($urandom_range(0, 6));
            w.rect_height = SIZE_W'($urandom_range(1, 3));
            row_bytes = int'(w.rect_width) * eff;
            if ($urandom_range(0, 9) < 7)
               w.line_pitch = PITCH_W'(row_bytes + $urandom_range(row_bytes == 0, 3));
            else
               w.line_pitch = PITCH_W'($urandom_range(1, row_bytes > 1 ? row_bytes : 1));
            if (roll > 95) w.rect_height = '0;
            else if (roll > 91) w.line_pitch = '0;
            n = int'(w.rect_height) * int'(w.line_pitch);
            if (n == 0) n = $urandom_range(1, 3);
            else if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
            if ($urandom_range(0, 6) == 0) n += $urandom_range(1, 2);
         end
         offer_word(w, 1'b0, '0);
         repeat (n) begin
            noise = {$urandom, $urandom, $urandom};
            w = noise[$bits(req_word_type)-1:0];
            w.cmd = CMD_DATA;
            w.final_byte = ($urandom_range(0, 9) == 0);
            offer_word(w, 1'b0, '0);
         end
         taken += 1 + n;
      end
   endtask

   // Result side: random stalls, with calm stretches
   initial begin : rsp_stalls
      int n;
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         n = $urandom_range(1, 30);
         repeat (n) @(posedge clock);
         n = pick_gap();
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   end

   // Compare each result word with the oldest booked one
   always @(posedge clock) begin : result_check
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (write_results_due.size() == 0) begin
            $error("result word with none expected: %h", rsp_word);
            fail_count++;
         end else begin
            want = write_results_due.pop_front();
            if (rsp_word.address !== want.address) begin
               $error("address: expected %0d, got %0d", want.address, rsp_word.address);
               fail_count++;
            end
            if (rsp_word.byte_value !== want.byte_value) begin
               $error("byte_value: expected %0d, got %0d", want.byte_value,
                      rsp_word.byte_value);
               fail_count++;
            end
            if (rsp_word.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_word.status);
               fail_count++;
            end
            if (rsp_word.rect_done !== want.rect_done) begin
               $error("rect_done: expected %0d, got %0d", want.rect_done,
                      rsp_word.rect_done);
               fail_count++;
            end
            if (rsp_word.list_done !== want.list_done) begin
               $error("list_done: expected %0d, got %0d", want.list_done,
                      rsp_word.list_done);
               fail_count++;
            end
            results_seen++;
            status_seen[want.status]++;
            if (want.rect_done) rects_closed++;
         end
      end
   end

   // Watchdog: too long without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= WATCHDOG_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed rectangles with reset register values (1024 x 1024, 4 bytes)
      plan.push_back('{dat(8'hA5, 0), 1'b1, res(0, 0, STATUS_NO_RECT, 0, 0)});
      plan.push_back('{dat(8'h00, 1), 1'b1, res(0, 0, STATUS_NO_RECT, 0, 1)});
      plan.push_back('{hdr(0, 0, 1, 1, 4), 1'b0, '0});
      plan.push_back('{dat(8'h11, 0), 1'b1, res(0, 8'h11, STATUS_WRITTEN, 0, 0)});
      plan.push_back('{dat(8'h22, 0), 1'b1, res(1, 8'h22, STATUS_WRITTEN, 0, 0)});
      plan.push_back('{dat(8'h33, 0), 1'b1, res(2, 8'h33, STATUS_WRITTEN, 0, 0)});
      plan.push_back('{dat(8'h44, 0), 1'b1, res(3, 8'h44, STATUS_WRITTEN, 1, 0)});
      plan.push_back('{dat(8'hFF, 0), 1'b1, res(0, 0, STATUS_NO_RECT, 0, 0)});
      // bottom-right corner: last frame pixel written, the next one dropped
      plan.push_back('{hdr(1023, 1023, 2, 1, 8), 1'b0, '0});
      for (int i = 0; i < 8; i++) plan.push_back('{dat(8'hF0 + i, 0), 1'b0, '0});
      // empty rectangles: zero height, zero pitch
      plan.push_back('{hdr(5, 5, 3, 0, 12), 1'b0, '0});
      plan.push_back('{dat(8'h5A, 0), 1'b1, res(0, 0, STATUS_NO_RECT, 0, 0)});
      plan.push_back('{hdr(5, 5, 3, 2, 0), 1'b0, '0});
      plan.push_back('{dat(8'hC3, 1), 1'b1, res(0, 0, STATUS_NO_RECT, 0, 1)});
      // all-ones header, then abandoned by a narrow-pitch rectangle
      plan.push_back('{hdr(1023, 1023, 2047, 2047, 8191), 1'b0, '0});
      plan.push_back('{dat(8'hFF, 1), 1'b0, '0});
      plan.push_back('{hdr(2, 1, 2047, 2, 2), 1'b0, '0});
      plan.push_back('{dat(8'h01, 0), 1'b0, '0});
      plan.push_back('{dat(8'h80, 0), 1'b0, '0});
      plan.push_back('{dat(8'h7F, 0), 1'b0, '0});
      plan.push_back('{dat(8'hFE, 1), 1'b0, '0});
      foreach (plan[i]) offer_word(plan[i].word, plan[i].typed, plan[i].known);

      // Random phases, each with its own frame setup
      for (int ph = 0; ph < 9; ph++) begin
         req_valid <= 1'b0;
         while (write_results_due.size() != 0) @(posedge clock);
         repeat (10) @(posedge clock);
         steady = ($urandom_range(0, 3) == 0);
         case (ph)
            0: program_frame(11'd1, 11'd1, 11'd1);
            1: program_frame(11'd2047, 11'd2047, 11'd7);
            2: program_frame(11'd16, 11'd8, 11'd3);
            3: program_frame(11'd5, 11'd3, 11'd0);
            4: program_frame(11'd0, 11'd4, 11'd2);
            5: program_frame(11'd1024, 11'd1024, 11'd4);
            6: program_frame(SIZE_W'($urandom_range(1, 40)),
                             SIZE_W'($urandom_range(1, 40)),
                             SIZE_W'($urandom_range(1, 4)));
            default: program_frame(SIZE_W'($urandom), SIZE_W'($urandom),
                                   SIZE_W'($urandom));
         endcase
         run_phase(PHASE_QUOTA);
      end

      // Drain
      req_valid <= 1'b0;
      while (write_results_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Covered %0d input words and %0d result words over 9 frame setups;",
               words_in, results_seen);
      $display("written %0d, padding %0d, outside %0d, no rectangle %0d, %0d rects closed",
               status_seen[STATUS_WRITTEN], status_seen[STATUS_PADDING],
               status_seen[STATUS_OUTSIDE], status_seen[STATUS_NO_RECT], rects_closed);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/rpfw_pkg.sv
sv/rpfw_ctrl.sv
sv/rpfw_datapath.sv
sv/rect_patch_frame_writer.sv
bench/rect_patch_frame_writer_tb.sv
